/* src/ibr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ibr_pkg;

   localparam int HEADER_BYTES   = 16;
   localparam int TRAINER_BYTES  = 512;
   localparam int PRG_BANK_BYTES = 16384;
   localparam int CHR_BANK_BYTES = 8192;

   // "NES" followed by the DOS end-of-file byte
   localparam logic [7:0] MAGIC [4] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

   typedef enum logic [2:0] {
      REGION_HEADER  = 3'd0,
      REGION_TRAINER = 3'd1,
      REGION_PRG     = 3'd2,
      REGION_CHR     = 3'd3,
      REGION_SURPLUS = 3'd4,
      REGION_REJECT  = 3'd5
   } ibr_region_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       first_byte;
   } ibr_req_type;

   typedef struct packed {
      ibr_region_type region;
      logic [7:0]     bank_index;
      logic [13:0]    bank_offset;
      logic [7:0]     byte_out;
      logic           header_ok;
      logic [1:0]     mirroring_mode;
      logic [7:0]     mapper_number;
      logic [7:0]     prg_bank_count;
      logic [7:0]     chr_bank_count;
      logic [7:0]     ram_bank_count;
      logic           trainer_present;
   } ibr_rsp_type;

endpackage
`default_nettype wire

/* src/ibr_state.sv */
`timescale 1ns / 1ps
`default_nettype none
module ibr_state (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire ibr_pkg::ibr_req_type req,
   output ibr_pkg::ibr_rsp_type     rsp
);
   import ibr_pkg::*;

   ibr_region_type phase_ff, phase_in, ph;
   logic           magic_good_ff, magic_good_in, mg;
   logic [7:0]     bank_ff, bank_in, bank;
   logic [13:0]    offset_ff, offset_in, off;
   logic [7:0]     prg_ff, prg_in;
   logic [7:0]     chr_ff, chr_in;
   logic [7:0]     ctl1_ff, ctl1_in;
   logic [7:0]     ctl2_ff, ctl2_in;
   logic [7:0]     ram_ff, ram_in;
   logic [7:0]     bank_next;
   logic [7:0]     b;
   ibr_region_type region;
   logic [7:0]     bidx;
   logic [13:0]    boff;

   always_comb begin
      b = req.file_byte;
      // a marked first byte sees the reset state
      if (req.first_byte) begin
         ph = REGION_HEADER; mg = 1'b1; bank = '0; off = '0;
         prg_in = '0; chr_in = '0; ctl1_in = '0; ctl2_in = '0; ram_in = '0;
      end else begin
         ph = phase_ff; mg = magic_good_ff; bank = bank_ff; off = offset_ff;
         prg_in = prg_ff; chr_in = chr_ff; ctl1_in = ctl1_ff;
         ctl2_in = ctl2_ff; ram_in = ram_ff;
      end
      phase_in      = ph;
      magic_good_in = mg;
      bank_in       = bank;
      offset_in     = off;
      bank_next     = bank + 8'd1;
      region        = ph;
      bidx          = '0;
      boff          = '0;
      case (ph)
         REGION_HEADER: begin
            boff = off;
            if (off < 14'd4 && b != MAGIC[off[1:0]]) begin
               magic_good_in = 1'b0;
               phase_in      = REGION_REJECT;
               offset_in     = '0;
            end else begin
               if (off == 14'd4) prg_in  = b;
               if (off == 14'd5) chr_in  = b;
               if (off == 14'd6) ctl1_in = b;
               if (off == 14'd7) ctl2_in = b;
               if (off == 14'd8) ram_in  = b;
               if (off >= 14'(HEADER_BYTES - 1)) begin
                  offset_in = '0;
                  bank_in   = '0;
                  if (ctl1_in[2])            phase_in = REGION_TRAINER;
                  else if (prg_in != 8'd0)   phase_in = REGION_PRG;
                  else if (chr_in != 8'd0)   phase_in = REGION_CHR;
                  else                       phase_in = REGION_SURPLUS;
               end else begin
                  offset_in = off + 14'd1;
               end
            end
         end
         REGION_TRAINER: begin
            boff = off;
            if (off >= 14'(TRAINER_BYTES - 1)) begin
               offset_in = '0;
               bank_in   = '0;
               if (prg_in != 8'd0)      phase_in = REGION_PRG;
               else if (chr_in != 8'd0) phase_in = REGION_CHR;
               else                     phase_in = REGION_SURPLUS;
            end else begin
               offset_in = off + 14'd1;
            end
         end
         REGION_PRG: begin
            bidx = bank;
            boff = off;
            if (off >= 14'(PRG_BANK_BYTES - 1)) begin
               offset_in = '0;
               bank_in   = bank_next;
               // wrap of the bank counter also ends the section
               if (bank_next >= prg_in || bank_next == 8'd0) begin
                  bank_in  = '0;
                  phase_in = (chr_in != 8'd0) ? REGION_CHR : REGION_SURPLUS;
               end
            end else begin
               offset_in = off + 14'd1;
            end
         end
         REGION_CHR: begin
            bidx = bank;
            boff = off;
            if (off >= 14'(CHR_BANK_BYTES - 1)) begin
               offset_in = '0;
               bank_in   = bank_next;
               if (bank_next >= chr_in || bank_next == 8'd0) begin
                  bank_in  = '0;
                  phase_in = REGION_SURPLUS;
               end
            end else begin
               offset_in = off + 14'd1;
            end
         end
         REGION_SURPLUS: begin
         end
         default: begin
            region   = REGION_REJECT;
            phase_in = REGION_REJECT;
         end
      endcase

      rsp.region          = region;
      rsp.bank_index      = bidx;
      rsp.bank_offset     = boff;
      rsp.byte_out        = b;
      rsp.header_ok       = magic_good_in &&
                            (phase_in == REGION_TRAINER || phase_in == REGION_PRG ||
                             phase_in == REGION_CHR || phase_in == REGION_SURPLUS);
      rsp.mirroring_mode  = ctl1_in[3] ? 2'd3 : {1'b0, ctl1_in[0]};
      rsp.mapper_number   = {ctl2_in[7:4], ctl1_in[7:4]};
      rsp.prg_bank_count  = prg_in;
      rsp.chr_bank_count  = chr_in;
      rsp.ram_bank_count  = ram_in;
      rsp.trainer_present = ctl1_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= REGION_HEADER;
         magic_good_ff <= 1'b1;
         bank_ff       <= '0;
         offset_ff     <= '0;
         prg_ff        <= '0;
         chr_ff        <= '0;
         ctl1_ff       <= '0;
         ctl2_ff       <= '0;
         ram_ff        <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         magic_good_ff <= magic_good_in;
         bank_ff       <= bank_in;
         offset_ff     <= offset_in;
         prg_ff        <= prg_in;
         chr_ff        <= chr_in;
         ctl1_ff       <= ctl1_in;
         ctl2_ff       <= ctl2_in;
         ram_ff        <= ram_in;
      end
   end

endmodule
`default_nettype wire

/* src/ines_image_byte_router_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Cartridge image byte router. Feed the image one byte per transaction, with
// first_byte set on the byte that opens a new image; every byte comes back
// tagged as header, trainer, PRG, CHR, surplus or rejected, with bank number,
// offset and the header fields latched so far. One byte is taken every cycle
// unless req_stall is raised; its tag passes through an input register, then the
// single parser state update per byte, then the result register. A stalled
// result holds up the input only once the input register is also full.
module ines_image_byte_router_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ibr_pkg::ibr_req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ibr_pkg::ibr_rsp_type      rsp_payload
);
   import ibr_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   ibr_req_type s1_req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   ibr_rsp_type rsp_ff;
   ibr_rsp_type tag;
   logic        out_load, advance, req_take;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_load;
   assign req_stall = s1_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (s1_valid_ff && !advance);
      rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;
   end

   ibr_state u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (s1_req_ff),
      .rsp     (tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) s1_req_ff <= req_payload;
      if (advance)  rsp_ff    <= tag;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("buffered input transaction dropped");

   a_bank_region : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bank_index != 8'd0 |->
         (rsp_payload.region == REGION_PRG || rsp_payload.region == REGION_CHR))
      else $error("bank index outside a PRG or CHR byte");

   a_header_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.header_ok && rsp_payload.region == REGION_HEADER |->
         rsp_payload.bank_offset == 14'(HEADER_BYTES - 1))
      else $error("header reported complete before its last byte");

   a_reject_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.region == REGION_REJECT |->
         !rsp_payload.header_ok && rsp_payload.bank_offset == 14'd0)
      else $error("rejected byte carries header status or offset");
`endif

endmodule
`default_nettype wire
